@@ rtl/core/atnc_pkg.sv @@
// Shared types, constants and the tile lookup for the neighbor code autotiler.
// Used by atnc_lane, atnc_merge and autotile_neighbor_code_top; depends on nothing.
package atnc_pkg;

  localparam int MAX_WIDTH   = 64;   // default number of columns per row
  localparam int ROW_BITS_W  = 64;   // width of the row_bits field
  localparam int CFG_W       = 7;    // width of the row_width register
  localparam int TILE_W      = 6;
  localparam int COL_W       = 6;
  localparam int LANES       = 8;    // cells classified in parallel per cycle
  localparam int LANE_W      = 3;    // bits to select one lane
  localparam int OUT_DATA_W  = 16;   // tile and column, padded to whole bytes

  localparam logic [CFG_W-1:0]  ROW_WIDTH_RESET = 7'd64;
  localparam logic [TILE_W-1:0] EMPTY_TILE      = 6'd43;
  localparam logic [TILE_W-1:0] MISSING_TILE    = 6'd0;

  // Input kinds carried in tuser.
  localparam logic MODE_ROW   = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef logic [TILE_W-1:0] tile_t;

  // One group of lane results handed from the lanes to the output stage.
  typedef struct packed {
    tile_t [LANES-1:0]  tiles;
    logic [COL_W-1:0]   base;       // column of lane 0
    logic [LANE_W-1:0]  last_lane;  // highest lane that holds a real cell
    logic               row_end;    // the last group of the row
  } grp_t;

  // Maps the gated 8-bit neighbor code to a tileset index.
  // Code bits: left, up, right, down, up-left, up-right, down-left, down-right.
  function automatic tile_t tile_lookup(input logic [7:0] code);
    tile_t t;
    unique case (code)
      8'h8C: t = 6'd0;
      8'hCD: t = 6'd1;
      8'h49: t = 6'd2;
      8'h08: t = 6'd3;
      8'h7F: t = 6'd4;
      8'hBF: t = 6'd5;
      8'hCF: t = 6'd6;
      8'hAE: t = 6'd7;
      8'hFF: t = 6'd8;
      8'h5B: t = 6'd9;
      8'h0A: t = 6'd10;
      8'hDF: t = 6'd11;
      8'hEF: t = 6'd12;
      8'hAF: t = 6'd13;
      8'h26: t = 6'd14;
      8'h37: t = 6'd15;
      8'h23: t = 6'd16;
      8'h02: t = 6'd17;
      8'h4F: t = 6'd18;
      8'h2F: t = 6'd19;
      8'h5F: t = 6'd20;
      8'h04: t = 6'd21;
      8'h05: t = 6'd22;
      8'h01: t = 6'd23;
      8'h00: t = 6'd24;
      8'h1F: t = 6'd25;
      8'h8F: t = 6'd26;
      8'h3F: t = 6'd27;
      8'h2E: t = 6'd28;
      8'h1B: t = 6'd29;
      8'h4D: t = 6'd30;
      8'h8D: t = 6'd31;
      8'h0C: t = 6'd32;
      8'h0D: t = 6'd33;
      8'h09: t = 6'd34;
      8'h8E: t = 6'd35;
      8'h4B: t = 6'd36;
      8'h17: t = 6'd37;
      8'h27: t = 6'd38;
      8'h0E: t = 6'd39;
      8'h0F: t = 6'd40;
      8'h0B: t = 6'd41;
      8'h9F: t = 6'd44;
      8'h6F: t = 6'd45;
      8'h06: t = 6'd46;
      8'h07: t = 6'd47;
      8'h03: t = 6'd48;
      default: t = MISSING_TILE;
    endcase
    return t;
  endfunction

endpackage

@@ rtl/core/atnc_lane.sv @@
// One classification lane: turns the 3x3 neighborhood of a cell into a tile index.
// Depends on atnc_pkg for the tile type and lookup table.
module atnc_lane (
  input  logic [2:0]      up,    // row above: left, center, right
  input  logic [2:0]      mid,   // cell row:  left, center, right
  input  logic [2:0]      dn,    // row below: left, center, right
  output atnc_pkg::tile_t tile
);

  logic l, u, r, d, tl, tr, bl, br;
  logic [7:0] code;

  always_comb begin
    l  = mid[0];
    u  = up[1];
    r  = mid[2];
    d  = dn[1];
    // A corner counts only when both edges next to it are filled.
    tl = up[0] & l & u;
    tr = up[2] & r & u;
    bl = dn[0] & l & d;
    br = dn[2] & r & d;
    code = {br, bl, tr, tl, d, r, u, l};
    if (mid[1]) begin
      tile = atnc_pkg::tile_lookup(code);
    end else begin
      tile = atnc_pkg::EMPTY_TILE;
    end
  end

endmodule

@@ rtl/core/atnc_merge.sv @@
// Output stage: holds one group of lane results and sends them one cell per transfer.
// Depends on atnc_pkg for the group struct and field widths.
module atnc_merge (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  atnc_pkg::grp_t                      in_grp,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [atnc_pkg::OUT_DATA_W-1:0]     m_tdata,   // tile_index, column, zero pad
  output logic                                m_tlast    // last_of_row
);

  atnc_pkg::grp_t                   grp;
  logic                             grp_valid;
  logic [atnc_pkg::LANE_W-1:0]      sel;
  logic                             send;
  logic                             done;
  logic [atnc_pkg::COL_W-1:0]       column;

  assign send     = grp_valid && m_tready;
  assign done     = send && (sel == grp.last_lane);
  assign in_ready = !grp_valid || done;

  // The group base is a multiple of the lane count, so the lane number drops in below it.
  assign column   = grp.base | atnc_pkg::COL_W'(sel);
  assign m_tvalid = grp_valid;
  assign m_tlast  = grp.row_end && (sel == grp.last_lane);
  assign m_tdata  = {{(atnc_pkg::OUT_DATA_W - atnc_pkg::COL_W - atnc_pkg::TILE_W){1'b0}},
                     column, grp.tiles[sel]};

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      sel       <= '0;
    end else if (in_valid && in_ready) begin
      grp_valid <= 1'b1;
      sel       <= '0;
    end else if (done) begin
      grp_valid <= 1'b0;
    end else if (send) begin
      sel <= sel + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      grp <= in_grp;
    end
  end

endmodule

@@ rtl/core/autotile_neighbor_code_top.sv @@
// Top level of the blob autotile neighbor code classifier.
// Depends on atnc_pkg, atnc_lane and atnc_merge.
//
// Usage: each transfer on the s_ channel carries one map row (s_tuser = 0, s_tdata bit k
// is column k, 1 = filled) or an end-of-frame flush (s_tuser = 1, s_tdata ignored).
// The block holds two rows. A row transfer emits one result per used column for the row
// before it; the first row of a frame only gets stored. A flush emits the held row with a
// filled border below it and empties the block; a flush with nothing held emits nothing.
// Results leave on the m_ channel: m_tdata[5:0] is the tile index (43 for an empty cell),
// m_tdata[11:6] the column, and m_tlast marks the last column of the row.
// The cfg_wen / cfg_wdata port sets the number of used columns; write it only while idle.
// The input transfer loads the row job register; the lanes then pass each group into
// the output stage's group buffer, which drives m_tvalid.
// Throughput: eight lanes classify eight cells per cycle into a group buffer while it
// has room, and the output stage sends one cell per cycle while m_tready is high. The
// next input transfer is taken in the same cycle in which the lanes hand the last group
// of the current row to the output stage, so rows stream back to back.
// Reset clears the held-row count, the width register (to 64) and all valid flags.
// When the receiver stalls, the group buffer and then the lane stage fill, and s_tready
// drops until the pending row has been handed over; nothing is dropped.
module autotile_neighbor_code_top #(
  parameter int MAX_WIDTH = atnc_pkg::MAX_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input rows.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [atnc_pkg::ROW_BITS_W-1:0]     s_tdata,   // row_bits
  input  logic                                s_tuser,   // mode
  // Results.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [atnc_pkg::OUT_DATA_W-1:0]     m_tdata,   // tile_index, column, zero pad
  output logic                                m_tlast,   // last_of_row
  // Width register.
  input  logic                                cfg_wen,
  input  logic [atnc_pkg::CFG_W-1:0]          cfg_wdata  // row_width
);

  localparam int LANES  = atnc_pkg::LANES;
  localparam int LANE_W = atnc_pkg::LANE_W;
  localparam int NGRP   = (MAX_WIDTH + LANES - 1) / LANES;
  localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
  // Rows extended with a filled cell left of column 0 and filled cells past the end.
  localparam int EXT_W  = NGRP * LANES + 2;

  // Held rows. Their contents are only read after they have been written.
  logic [MAX_WIDTH-1:0]            upper_row;
  logic [MAX_WIDTH-1:0]            middle_row;
  logic [1:0]                      rows_held;
  logic [atnc_pkg::CFG_W-1:0]      row_width;

  // The row job that the lanes are working through, one group per cycle unless stalled.
  logic                            job_valid;
  logic [MAX_WIDTH-1:0]            job_up;
  logic [MAX_WIDTH-1:0]            job_mid;
  logic [MAX_WIDTH-1:0]            job_dn;
  logic [GRP_W-1:0]                job_group;
  logic [GRP_W-1:0]                job_last_grp;
  logic [LANE_W-1:0]               job_last_lane;

  logic [atnc_pkg::CFG_W-1:0]      eff_w;
  logic [atnc_pkg::CFG_W-1:0]      wm1;
  logic [MAX_WIDTH-1:0]            used;
  logic [MAX_WIDTH-1:0]            in_row;
  logic [MAX_WIDTH-1:0]            pad_upper;
  logic [MAX_WIDTH-1:0]            pad_middle;
  logic [MAX_WIDTH-1:0]            pad_in;
  logic                            s_fire;
  logic                            job_load;
  logic [MAX_WIDTH-1:0]            load_dn;

  logic [EXT_W-1:0]                ext_up;
  logic [EXT_W-1:0]                ext_mid;
  logic [EXT_W-1:0]                ext_dn;
  logic [LANES+1:0]                win_up;
  logic [LANES+1:0]                win_mid;
  logic [LANES+1:0]                win_dn;
  logic [GRP_W+LANE_W-1:0]         win_base;
  atnc_pkg::tile_t [LANES-1:0]     lane_tile;
  atnc_pkg::grp_t                  grp_next;
  logic                            grp_ready;
  logic                            grp_take;

  // A width of zero acts as one; anything past the maximum saturates.
  always_comb begin
    if (row_width == '0) begin
      eff_w = atnc_pkg::CFG_W'(1);
    end else if (row_width > atnc_pkg::CFG_W'(MAX_WIDTH)) begin
      eff_w = atnc_pkg::CFG_W'(MAX_WIDTH);
    end else begin
      eff_w = row_width;
    end
    wm1 = eff_w - 1'b1;
  end

  // Columns at or past the width read as filled border.
  always_comb begin
    for (int k = 0; k < MAX_WIDTH; k++) begin
      used[k] = (atnc_pkg::CFG_W'(k) < eff_w);
    end
  end

  assign in_row     = s_tdata[MAX_WIDTH-1:0];
  assign pad_upper  = (upper_row & used) | ~used;
  assign pad_middle = (middle_row & used) | ~used;
  assign pad_in     = (in_row & used) | ~used;

  // A new row is taken as soon as the lanes hand over the last group of the current job.
  assign s_tready = !job_valid || (grp_take && (job_group == job_last_grp));
  assign s_fire   = s_tvalid && s_tready;
  // Every accepted item emits a row unless nothing is held yet.
  assign job_load = s_fire && (rows_held != 2'd0);
  assign load_dn  = (s_tuser == atnc_pkg::MODE_FLUSH) ? '1 : pad_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= atnc_pkg::ROW_WIDTH_RESET;
    end else if (cfg_wen) begin
      row_width <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_held <= 2'd0;
    end else if (s_fire) begin
      if (s_tuser == atnc_pkg::MODE_FLUSH) begin
        rows_held <= 2'd0;
      end else if (rows_held == 2'd0) begin
        rows_held <= 2'd1;
      end else begin
        rows_held <= 2'd2;
      end
    end
  end

  // The first row of a frame gets a filled border above it.
  always_ff @(posedge clk) begin
    if (s_fire && (s_tuser == atnc_pkg::MODE_ROW)) begin
      if (rows_held == 2'd0) begin
        upper_row <= '1;
      end else begin
        upper_row <= middle_row;
      end
      middle_row <= in_row;
    end
  end

  assign grp_take = job_valid && grp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      job_group <= '0;
    end else if (job_load) begin
      job_valid <= 1'b1;
      job_group <= '0;
    end else if (grp_take) begin
      if (job_group == job_last_grp) begin
        job_valid <= 1'b0;
      end else begin
        job_group <= job_group + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job_up        <= pad_upper;
      job_mid       <= pad_middle;
      job_dn        <= load_dn;
      job_last_grp  <= GRP_W'(wm1 >> LANE_W);
      job_last_lane <= wm1[LANE_W-1:0];
    end
  end

  // Each lane sees its own column and one neighbor on either side.
  assign ext_up   = {{(EXT_W - MAX_WIDTH - 1){1'b1}}, job_up, 1'b1};
  assign ext_mid  = {{(EXT_W - MAX_WIDTH - 1){1'b1}}, job_mid, 1'b1};
  assign ext_dn   = {{(EXT_W - MAX_WIDTH - 1){1'b1}}, job_dn, 1'b1};
  assign win_base = {job_group, {LANE_W{1'b0}}};
  assign win_up   = ext_up[win_base +: LANES + 2];
  assign win_mid  = ext_mid[win_base +: LANES + 2];
  assign win_dn   = ext_dn[win_base +: LANES + 2];

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    atnc_lane u_lane (
      .up   (win_up[k +: 3]),
      .mid  (win_mid[k +: 3]),
      .dn   (win_dn[k +: 3]),
      .tile (lane_tile[k])
    );
  end

  always_comb begin
    grp_next.tiles     = lane_tile;
    grp_next.base      = atnc_pkg::COL_W'(win_base);
    grp_next.row_end   = (job_group == job_last_grp);
    grp_next.last_lane = (job_group == job_last_grp) ? job_last_lane : {LANE_W{1'b1}};
  end

  atnc_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (job_valid),
    .in_ready (grp_ready),
    .in_grp   (grp_next),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // The held-row count never reaches three.
  a_rows_held_range: assert property (@(posedge clk) disable iff (rst)
    rows_held != 2'd3)
    else $error("rows_held out of range");

  // The group counter never runs past the last group of its row.
  a_job_group_bound: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> job_group <= job_last_grp)
    else $error("job group past end of row");

  // A new row job always starts at its first group.
  a_job_start: assert property (@(posedge clk) disable iff (rst)
    $rose(job_valid) |-> job_group == '0)
    else $error("row job did not start at group zero");

  // A transfer that finds nothing held never starts a row job.
  a_no_job_empty: assert property (@(posedge clk) disable iff (rst)
    (s_fire && rows_held == 2'd0) |=> !job_valid)
    else $error("row job started with no held row");

endmodule
